@@ sv/wsvm_pkg.sv @@
package wsvm_pkg;

  // Fixed field widths of the item and register interface.
  localparam int PHASE_BITS      = 32;
  localparam int LEVEL_BITS      = 16;
  localparam int STEP_BITS       = 16;
  localparam int TABLE_BITS      = 12;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 12;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_IDX_BITS    = 2;

  // Fixed-point shifts of the mixing path.
  localparam int AMP_SHIFT = 6;
  localparam int MIX_SHIFT = 11;
  localparam int OUT_SHIFT = 2;
  localparam int AMP_BITS  = LEVEL_BITS - AMP_SHIFT;
  localparam int TERM_BITS = AMP_BITS + 1 + TABLE_BITS - MIX_SHIFT + 1;

  // Request codes.
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
  localparam logic [1:0] REQ_NOTE_OFF = 2'd2;
  localparam logic [1:0] REQ_TBL_WR   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAVE_SEL = 2'd2;

  // Register reset values.
  localparam logic [STEP_BITS-1:0] ATTACK_RESET   = 16'd20;
  localparam logic [STEP_BITS-1:0] RELEASE_RESET  = 16'd5;
  localparam logic [2:0]           WAVE_SEL_RESET = 3'd4;

  typedef enum logic [1:0] {
    ENV_IDLE,
    ENV_ATTACK,
    ENV_SUSTAIN,
    ENV_RELEASE
  } env_stage_e;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic acc;
  } mac_ctl_t;

endpackage

@@ sv/wavetable_synth_voice_mixer_top.sv @@
// A tick item walks every voice in turn and produces one registered sample; busy stays
// high until that sample is registered, so no item is taken while a tick is in work.
// Each voice passes an update state, which reads its envelope and addresses its table
// entry, and a multiply state on the shared multiplier; an output state clamps the sum.
// Other items give no result. Reset clears voices and the sequencer and loads the
// registers with their reset values; the receiver cannot stall results.
module wavetable_synth_voice_mixer_top import wsvm_pkg::*; #(
  parameter int VOICE_COUNT = 8,
  parameter int WAVE_COUNT  = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type_i,
  input  logic [2:0]                   voice_id_i,
  input  logic [PHASE_BITS-1:0]        phase_step_i,
  input  logic [LEVEL_BITS-1:0]        sustain_level_i,
  input  logic [2:0]                   table_id_i,
  input  logic [9:0]                   table_addr_i,
  input  logic signed [TABLE_BITS-1:0] table_value_i,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data_i,
  output logic                         sample_valid_o,
  output logic [SAMPLE_BITS-1:0]       sample_out_o
);

  // Voice counter and wave table addressing widths follow from the parameters.
  localparam int VID_BITS  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int WID_BITS  = (WAVE_COUNT > 1) ? $clog2(WAVE_COUNT) : 1;
  localparam int MEM_ABITS = WID_BITS + TABLE_ADDR_BITS;
  localparam int MEM_DEPTH = WAVE_COUNT << TABLE_ADDR_BITS;
  localparam int ACC_BITS  = TERM_BITS + VID_BITS + 2;
  localparam int OUT_TOP   = (1 << SAMPLE_BITS) - 1;
  localparam int OUT_MID   = 1 << (SAMPLE_BITS - 1);

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_UPDATE,
    SEQ_MAC,
    SEQ_OUT
  } seq_state_e;

  // Configuration registers.
  logic [STEP_BITS-1:0] attack_step_q;
  logic [STEP_BITS-1:0] release_step_q;
  logic [2:0]           wave_sel_q;

  // Per-voice state, held in flip-flops and read at the sequencer's voice index.
  logic [PHASE_BITS-1:0] phase_acc_q [VOICE_COUNT];
  logic [PHASE_BITS-1:0] phase_inc_q [VOICE_COUNT];
  logic [LEVEL_BITS-1:0] env_level_q [VOICE_COUNT];
  logic [LEVEL_BITS-1:0] peak_level_q [VOICE_COUNT];
  env_stage_e            env_stage_q [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] key_rel_q;

  // Sequencer state and registered outputs.
  seq_state_e            state_q;
  logic [VID_BITS-1:0]   vidx_q;
  logic                  act_q;
  logic [AMP_BITS-1:0]   amp_q;
  logic                  valid_q;
  logic [SAMPLE_BITS-1:0] sample_q;

  logic                  accept;
  logic                  vid_ok;
  logic [VID_BITS-1:0]   vid;
  logic                  last_voice;
  env_stage_e            step_stage;
  logic [LEVEL_BITS-1:0] step_level;
  logic [LEVEL_BITS-1:0] step_amp;
  logic [PHASE_BITS-1:0] step_phase;
  logic [WID_BITS-1:0]   sel;
  logic                  mem_we;
  logic [MEM_ABITS-1:0]  mem_addr;
  logic [TABLE_BITS-1:0] mem_rdata;
  mac_ctl_t              mac_ctl;
  logic signed [ACC_BITS-1:0] mix_sum;
  logic signed [ACC_BITS-1:0] mix_sh;
  logic signed [ACC_BITS:0]   mix_off;
  logic [SAMPLE_BITS-1:0]     mix_clamped;

  assign busy       = (state_q != SEQ_IDLE);
  assign accept     = start && !busy;
  assign vid_ok     = (32'(voice_id_i) < VOICE_COUNT);
  assign vid        = VID_BITS'(voice_id_i);
  assign last_voice = (vidx_q == VID_BITS'(VOICE_COUNT - 1));

  // An out-of-range wave select falls back to the last table.
  assign sel = (32'(wave_sel_q) < WAVE_COUNT) ? WID_BITS'(wave_sel_q)
                                              : WID_BITS'(WAVE_COUNT - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_step_q  <= ATTACK_RESET;
      release_step_q <= RELEASE_RESET;
      wave_sel_q     <= WAVE_SEL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ATTACK:   attack_step_q  <= cfg_data_i;
        CFG_RELEASE:  release_step_q <= cfg_data_i;
        CFG_WAVE_SEL: wave_sel_q     <= cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  wsvm_voice_step u_step (
    .stage_i        (env_stage_q[vidx_q]),
    .level_i        (env_level_q[vidx_q]),
    .peak_i         (peak_level_q[vidx_q]),
    .key_rel_i      (key_rel_q[vidx_q]),
    .phase_i        (phase_acc_q[vidx_q]),
    .inc_i          (phase_inc_q[vidx_q]),
    .attack_step_i  (attack_step_q),
    .release_step_i (release_step_q),
    .stage_o        (step_stage),
    .level_o        (step_level),
    .amp_o          (step_amp),
    .phase_o        (step_phase)
  );

  // Voice state: note events arrive while the sequencer is idle, envelope steps
  // only while it walks the voices, so the two writers never collide.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        phase_acc_q[i]  <= '0;
        phase_inc_q[i]  <= '0;
        env_level_q[i]  <= '0;
        peak_level_q[i] <= '0;
        env_stage_q[i]  <= ENV_IDLE;
      end
      key_rel_q <= '1;
    end else if (accept && vid_ok && req_type_i == REQ_NOTE_ON) begin
      // The phase accumulator keeps running across a retrigger.
      phase_inc_q[vid]  <= phase_step_i;
      peak_level_q[vid] <= sustain_level_i;
      env_level_q[vid]  <= '0;
      env_stage_q[vid]  <= ENV_ATTACK;
      key_rel_q[vid]    <= 1'b0;
    end else if (accept && vid_ok && req_type_i == REQ_NOTE_OFF) begin
      key_rel_q[vid] <= 1'b1;
    end else if (state_q == SEQ_UPDATE && env_stage_q[vidx_q] != ENV_IDLE) begin
      phase_acc_q[vidx_q] <= step_phase;
      env_level_q[vidx_q] <= step_level;
      env_stage_q[vidx_q] <= step_stage;
    end
  end

  // The wave table port writes on a table write item and otherwise reads the
  // entry at the top bits of the updated phase of the current voice.
  assign mem_we   = accept && (req_type_i == REQ_TBL_WR) && (32'(table_id_i) < WAVE_COUNT);
  assign mem_addr = mem_we ? {WID_BITS'(table_id_i), table_addr_i[TABLE_ADDR_BITS-1:0]}
                           : {sel, step_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS]};

  wsvm_ram #(
    .WIDTH     (TABLE_BITS),
    .ADDR_BITS (MEM_ABITS),
    .DEPTH     (MEM_DEPTH)
  ) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (table_value_i),
    .rdata_o (mem_rdata)
  );

  assign mac_ctl.clear = accept && (req_type_i == REQ_TICK);
  assign mac_ctl.acc   = (state_q == SEQ_MAC) && act_q;

  wsvm_mac #(
    .ACC_BITS (ACC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .amp_i    (amp_q),
    .sample_i ($signed(mem_rdata)),
    .sum_o    (mix_sum)
  );

  // Final mix: floor divide by four, re-center and clamp to the unsigned range.
  assign mix_sh  = mix_sum >>> OUT_SHIFT;
  assign mix_off = (ACC_BITS + 1)'(mix_sh) + (ACC_BITS + 1)'(OUT_MID);

  always_comb begin
    if (mix_off < 0) begin
      mix_clamped = '0;
    end else if (mix_off > (ACC_BITS + 1)'(OUT_TOP)) begin
      mix_clamped = SAMPLE_BITS'(OUT_TOP);
    end else begin
      mix_clamped = mix_off[SAMPLE_BITS-1:0];
    end
  end

  // Sequencer: each voice gets an update cycle, in which its table entry is
  // addressed, and a multiply cycle, in which the read data is accumulated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEQ_IDLE;
      vidx_q   <= '0;
      act_q    <= 1'b0;
      amp_q    <= '0;
      valid_q  <= 1'b0;
      sample_q <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        SEQ_IDLE: begin
          if (accept && req_type_i == REQ_TICK) begin
            vidx_q  <= '0;
            state_q <= SEQ_UPDATE;
          end
        end
        SEQ_UPDATE: begin
          act_q   <= (env_stage_q[vidx_q] != ENV_IDLE);
          amp_q   <= step_amp[LEVEL_BITS-1:AMP_SHIFT];
          state_q <= SEQ_MAC;
        end
        SEQ_MAC: begin
          if (last_voice) begin
            state_q <= SEQ_OUT;
          end else begin
            vidx_q  <= vidx_q + VID_BITS'(1);
            state_q <= SEQ_UPDATE;
          end
        end
        SEQ_OUT: begin
          sample_q <= mix_clamped;
          valid_q  <= 1'b1;
          state_q  <= SEQ_IDLE;
        end
        default: begin
          state_q <= SEQ_IDLE;
        end
      endcase
    end
  end

  assign sample_valid_o = valid_q;
  assign sample_out_o   = sample_q;

endmodule

@@ sv/wsvm_ram.sv @@
module wsvm_ram #(
  parameter int WIDTH     = 12,
  parameter int ADDR_BITS = 13,
  parameter int DEPTH     = 5120
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/wsvm_voice_step.sv @@
module wsvm_voice_step import wsvm_pkg::*; (
  input  env_stage_e              stage_i,
  input  logic [LEVEL_BITS-1:0]   level_i,
  input  logic [LEVEL_BITS-1:0]   peak_i,
  input  logic                    key_rel_i,
  input  logic [PHASE_BITS-1:0]   phase_i,
  input  logic [PHASE_BITS-1:0]   inc_i,
  input  logic [STEP_BITS-1:0]    attack_step_i,
  input  logic [STEP_BITS-1:0]    release_step_i,
  output env_stage_e              stage_o,
  output logic [LEVEL_BITS-1:0]   level_o,
  output logic [LEVEL_BITS-1:0]   amp_o,
  output logic [PHASE_BITS-1:0]   phase_o
);

  logic [LEVEL_BITS:0] rise;

  assign rise    = {1'b0, level_i} + {1'b0, attack_step_i};
  assign phase_o = phase_i + inc_i;

  // One envelope step; the amplitude used for mixing is the level before the step.
  always_comb begin
    stage_o = stage_i;
    level_o = level_i;
    amp_o   = level_i;
    case (stage_i)
      ENV_ATTACK: begin
        if (rise >= {1'b0, peak_i}) begin
          level_o = peak_i;
          stage_o = ENV_SUSTAIN;
        end else begin
          level_o = rise[LEVEL_BITS-1:0];
        end
      end
      ENV_SUSTAIN: begin
        amp_o = peak_i;
        if (key_rel_i) begin
          level_o = peak_i;
          stage_o = ENV_RELEASE;
        end
      end
      ENV_RELEASE: begin
        if (level_i <= release_step_i) begin
          level_o = '0;
          stage_o = ENV_IDLE;
        end else begin
          level_o = level_i - release_step_i;
        end
      end
      default: begin
        amp_o = '0;
      end
    endcase
  end

endmodule

@@ sv/wsvm_mac.sv @@
module wsvm_mac import wsvm_pkg::*; #(
  parameter int ACC_BITS = 18
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mac_ctl_t                     ctl_i,
  input  logic [AMP_BITS-1:0]          amp_i,
  input  logic signed [TABLE_BITS-1:0] sample_i,
  output logic signed [ACC_BITS-1:0]   sum_o
);

  localparam int PROD_BITS = AMP_BITS + 1 + TABLE_BITS;

  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] prod_sh;
  logic signed [TERM_BITS-1:0] term;
  logic signed [ACC_BITS-1:0]  sum_d, sum_q;

  // Arithmetic shift floors the scaled product, as the mix requires.
  assign prod    = PROD_BITS'($signed({1'b0, amp_i})) * PROD_BITS'(sample_i);
  assign prod_sh = prod >>> MIX_SHIFT;
  assign term    = prod_sh[TERM_BITS-1:0];

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.clear) begin
      sum_d = '0;
    end else if (ctl_i.acc) begin
      sum_d = sum_q + ACC_BITS'(term);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ tb/tb_wavetable_synth_voice_mixer_top.sv @@
module tb_wavetable_synth_voice_mixer_top;
  import wsvm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default size: eight voices and five wave tables.
  localparam int VOICE_COUNT = 8;
  localparam int WAVE_COUNT  = 5;
  localparam int TABLE_LEN   = 1 << TABLE_ADDR_BITS;

  // A tick item keeps the sequencer busy until its sample shows up. The drain
  // time covers the walk from acceptance to that sample with a small margin.
  localparam int DRAIN_CYCLES = 2 * VOICE_COUNT + 4;

  // Largest number of cycles the sender waits before it offers an item.
  localparam int MAX_GAP = 13;

  // Number of random items sent under each register setting.
  localparam int ITEMS_PER_SETTING = 200;
  localparam int SETTING_COUNT     = 8;

  // Register index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  // Only the first few mismatches are printed in full.
  localparam int MAX_REPORTS = 10;

  // One request as seen on the input ports.
  typedef struct {
    logic [1:0]                   req;
    logic [2:0]                   voice;
    logic [PHASE_BITS-1:0]        phase_step;
    logic [LEVEL_BITS-1:0]        sustain;
    logic [2:0]                   table_id;
    logic [TABLE_ADDR_BITS-1:0]   addr;
    logic signed [TABLE_BITS-1:0] value;
  } synth_req_t;

  // The scoreboard keeps its own copy of the voice state, the wave tables and
  // the registers. Every accepted item is applied to that copy in order; a tick
  // item mixes all active voices and queues the sample the block must produce.
  class mixer_scoreboard;
    logic [PHASE_BITS-1:0]        phase_acc [VOICE_COUNT];
    logic [PHASE_BITS-1:0]        phase_inc [VOICE_COUNT];
    int                           env_level [VOICE_COUNT];
    int                           peak_level[VOICE_COUNT];
    env_stage_e                   env_stage [VOICE_COUNT];
    bit                           released  [VOICE_COUNT];
    logic signed [TABLE_BITS-1:0] wave_mem  [WAVE_COUNT][TABLE_LEN];
    int                           attack_step;
    int                           release_step;
    logic [2:0]                   wave_sel;
    logic [SAMPLE_BITS-1:0]       pending_samples[$];
    int                           error_count;

    function new();
      for (int v = 0; v < VOICE_COUNT; v++) begin
        phase_acc[v]  = '0;
        phase_inc[v]  = '0;
        env_level[v]  = 0;
        peak_level[v] = 0;
        env_stage[v]  = ENV_IDLE;
        released[v]   = 1'b1;
      end
      attack_step  = ATTACK_RESET;
      release_step = RELEASE_RESET;
      wave_sel     = WAVE_SEL_RESET;
      error_count  = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_ATTACK:   attack_step  = data;
        CFG_RELEASE:  release_step = data;
        CFG_WAVE_SEL: wave_sel     = data[2:0];
        default: ;
      endcase
    endfunction

    // Advances every active voice by one tick and returns the mixed sample.
    function logic [SAMPLE_BITS-1:0] mix_tick();
      int sum;
      int amp;
      int smp;
      int sel;
      int v;
      logic [TABLE_ADDR_BITS-1:0] idx;
      sum = 0;
      sel = (wave_sel < WAVE_COUNT) ? int'(wave_sel) : WAVE_COUNT - 1;
      for (v = 0; v < VOICE_COUNT; v++) begin
        if (env_stage[v] == ENV_IDLE) continue;
        phase_acc[v] = phase_acc[v] + phase_inc[v];
        case (env_stage[v])
          ENV_ATTACK: begin
            amp = env_level[v];
            env_level[v] += attack_step;
            if (env_level[v] >= peak_level[v]) begin
              env_level[v] = peak_level[v];
              env_stage[v] = ENV_SUSTAIN;
            end
          end
          ENV_SUSTAIN: begin
            amp = peak_level[v];
            if (released[v]) begin
              env_level[v] = peak_level[v];
              env_stage[v] = ENV_RELEASE;
            end
          end
          default: begin
            amp = env_level[v];
            env_level[v] -= release_step;
            if (env_level[v] <= 0) begin
              env_level[v] = 0;
              env_stage[v] = ENV_IDLE;
            end
          end
        endcase
        idx = phase_acc[v][PHASE_BITS-1 -: TABLE_ADDR_BITS];
        smp = wave_mem[sel][idx];
        sum += ((amp >>> AMP_SHIFT) * smp) >>> MIX_SHIFT;
      end
      sum = (sum >>> OUT_SHIFT) + (1 << (SAMPLE_BITS - 1));
      if (sum < 0) sum = 0;
      if (sum > (1 << SAMPLE_BITS) - 1) sum = (1 << SAMPLE_BITS) - 1;
      return sum[SAMPLE_BITS-1:0];
    endfunction

    function void note_item(synth_req_t it);
      case (it.req)
        REQ_NOTE_ON: begin
          phase_inc[it.voice]  = it.phase_step;
          peak_level[it.voice] = it.sustain;
          env_level[it.voice]  = 0;
          env_stage[it.voice]  = ENV_ATTACK;
          released[it.voice]   = 1'b0;
        end
        REQ_NOTE_OFF: released[it.voice] = 1'b1;
        REQ_TBL_WR: begin
          if (it.table_id < WAVE_COUNT) wave_mem[it.table_id][it.addr] = it.value;
        end
        default: pending_samples.push_back(mix_tick());
      endcase
    endfunction

    function void report_error(string what, logic [SAMPLE_BITS-1:0] want,
                               logic [SAMPLE_BITS-1:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s: expected sample_out %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_sample(logic [SAMPLE_BITS-1:0] got);
      logic [SAMPLE_BITS-1:0] want;
      if (pending_samples.size() == 0) begin
        report_error("sample with no tick waiting", 'x, got);
      end else begin
        want = pending_samples.pop_front();
        if (got !== want) report_error("sample mismatch", want, got);
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [1:0]                   req_type_i;
  logic [2:0]                   voice_id_i;
  logic [PHASE_BITS-1:0]        phase_step_i;
  logic [LEVEL_BITS-1:0]        sustain_level_i;
  logic [2:0]                   table_id_i;
  logic [9:0]                   table_addr_i;
  logic signed [TABLE_BITS-1:0] table_value_i;
  logic                         cfg_we_i;
  logic [CFG_IDX_BITS-1:0]      cfg_idx_i;
  logic [CFG_DATA_BITS-1:0]     cfg_data_i;
  logic                         sample_valid_o;
  logic [SAMPLE_BITS-1:0]       sample_out_o;

  mixer_scoreboard sb;

  // When set, the sender offers every item as soon as the block can take it.
  bit no_gaps;

  wavetable_synth_voice_mixer_top #(
    .VOICE_COUNT(VOICE_COUNT),
    .WAVE_COUNT (WAVE_COUNT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .voice_id_i     (voice_id_i),
    .phase_step_i   (phase_step_i),
    .sustain_level_i(sustain_level_i),
    .table_id_i     (table_id_i),
    .table_addr_i   (table_addr_i),
    .table_value_i  (table_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_valid_o (sample_valid_o),
    .sample_out_o   (sample_out_o)
  );

  always #10 clk_i = ~clk_i;

  // Samples are strobed for one cycle and cannot be held off, so every
  // rising edge with the strobe high is a sample that must match the oldest
  // pending tick. Values are read before the edge's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && sample_valid_o) sb.check_sample(sample_out_o);
  end

  // Offers one item. The task is entered at a rising edge, normally the one
  // that accepted the previous item. After an optional random pause the item
  // is put on the ports and held until an edge sees busy low. When there is
  // no pause, start simply stays high so it is never lowered and raised in
  // the same time step.
  task automatic send(logic [1:0] req, logic [2:0] voice, logic [PHASE_BITS-1:0] phase,
                      logic [LEVEL_BITS-1:0] level, logic [2:0] tid,
                      logic [TABLE_ADDR_BITS-1:0] addr, logic [TABLE_BITS-1:0] value);
    synth_req_t it;
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    it  = '{req, voice, phase, level, tid, addr, value};
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    req_type_i      <= req;
    voice_id_i      <= voice;
    phase_step_i    <= phase;
    sustain_level_i <= level;
    table_id_i      <= tid;
    table_addr_i    <= addr;
    table_value_i   <= value;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
  endtask

  // Drops start and waits until every pending sample has come back. Table and
  // note items give no sample, so the drain time follows to let any of those
  // still in the sequencer settle before a register changes.
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the scoreboard picks up the new value at the same edge
  // the block does.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.apply_reg(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int k;
    int n;
    int pick;
    logic [1:0]            req;
    logic [STEP_BITS-1:0]  atk;
    logic [STEP_BITS-1:0]  rel;
    logic [2:0]            sel;
    logic [LEVEL_BITS-1:0] level;
    logic [PHASE_BITS-1:0] phase;

    sb = new();
    no_gaps         = 1'b0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_type_i      = REQ_TICK;
    voice_id_i      = '0;
    phase_step_i    = '0;
    sustain_level_i = '0;
    table_id_i      = '0;
    table_addr_i    = '0;
    table_value_i   = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_ATTACK;
    cfg_data_i      = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every entry of every table is loaded with random content before any
    // note plays, so no tick can ever read an entry that was never written.
    for (k = 0; k < WAVE_COUNT; k++) begin
      for (n = 0; n < TABLE_LEN; n++) begin
        send(REQ_TBL_WR, 3'($urandom), $urandom, 16'($urandom), 3'(k),
             TABLE_ADDR_BITS'(n), 12'($urandom));
      end
    end

    // Directed items under the reset register values. A tick with every voice
    // idle must give the bare offset. A note off on an idle voice only sets its
    // flag. Voices start at the field extremes, one with a zero peak so its
    // attack ends at once. A note off during attack must let the attack finish
    // first, and a second note on to a sounding voice restarts it from zero.
    // Writes to table ids past the last table must leave the tables alone.
    send(REQ_TICK,     0, 0, 0, 0, 0, 0);
    send(REQ_NOTE_OFF, 3, 0, 0, 0, 0, 0);
    send(REQ_TICK,     0, 0, 0, 0, 0, 0);
    send(REQ_NOTE_ON,  0, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0);
    send(REQ_NOTE_ON,  1, 32'h0000_0000, 16'h0000, 0, 0, 0);
    send(REQ_NOTE_ON,  7, 32'h0040_0000, 16'd100, 0, 0, 0);
    repeat (3) send(REQ_TICK, 0, 0, 0, 0, 0, 0);
    send(REQ_NOTE_OFF, 7, 0, 0, 0, 0, 0);
    send(REQ_NOTE_OFF, 0, 0, 0, 0, 0, 0);
    repeat (2) send(REQ_TICK, 0, 0, 0, 0, 0, 0);
    send(REQ_NOTE_ON,  0, 32'h8000_0000, 16'd40, 0, 0, 0);
    repeat (3) send(REQ_TICK, 0, 0, 0, 0, 0, 0);
    send(REQ_TBL_WR,   0, 0, 0, 3'd5, 10'd0, 12'sd7);
    send(REQ_TBL_WR,   0, 0, 0, 3'd7, 10'd1023, 12'sd7);
    send(REQ_TBL_WR,   0, 0, 0, 3'd4, 10'd1023, 12'sd2047);
    send(REQ_TBL_WR,   0, 0, 0, 3'd4, 10'd0, -12'sd2048);
    repeat (2) send(REQ_TICK, 0, 0, 0, 0, 0, 0);

    // Random items under a series of register settings: the step extremes,
    // steps that stop the envelope in attack or release, medium steps that walk
    // voices through every stage, wave selects past the last table, and the
    // reset values again. Each setting also writes the unused register index,
    // and the wave select data carries random upper bits that must be dropped.
    for (k = 0; k < SETTING_COUNT; k++) begin
      wait_idle();
      case (k)
        0: begin
          atk = 16'hFFFF;
          rel = 16'hFFFF;
          sel = 3'd0;
        end
        1: begin
          atk = 16'h0000;
          rel = 16'h0000;
          sel = 3'd1;
        end
        2: begin
          atk = 16'($urandom_range(256, 4096));
          rel = 16'($urandom_range(256, 4096));
          sel = 3'd2;
        end
        3: begin
          atk = 16'($urandom_range(1024, 16384));
          rel = 16'($urandom_range(64, 2048));
          sel = 3'd3;
        end
        4: begin
          atk = 16'($urandom);
          rel = 16'($urandom);
          sel = 3'd5;
        end
        5: begin
          atk = 16'($urandom_range(2000, 20000));
          rel = 16'($urandom_range(2000, 20000));
          sel = 3'd6;
        end
        6: begin
          atk = 16'($urandom);
          rel = 16'($urandom_range(1, 1024));
          sel = 3'd7;
        end
        default: begin
          atk = ATTACK_RESET;
          rel = RELEASE_RESET;
          sel = WAVE_SEL_RESET;
        end
      endcase
      write_reg(CFG_ATTACK, atk);
      write_reg(CFG_RELEASE, rel);
      write_reg(CFG_WAVE_SEL, {13'($urandom), sel});
      write_reg(CFG_SPARE, 16'($urandom));

      // Every third setting runs back to back so the block sees long stretches
      // with no pause between items.
      no_gaps = (k % 3 == 2);

      // Ticks dominate so envelopes keep moving; note on and off keep voices
      // cycling through attack, sustain and release. Fields that a request
      // does not use still carry random values.
      for (n = 0; n < ITEMS_PER_SETTING; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      req = REQ_TICK;
        else if (pick < 65) req = REQ_NOTE_ON;
        else if (pick < 85) req = REQ_NOTE_OFF;
        else                req = REQ_TBL_WR;
        level = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        phase = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 32'h0100_0000));
        send(req, 3'($urandom), phase, level, 3'($urandom), TABLE_ADDR_BITS'($urandom),
             12'($urandom));
      end
    end

    // Let the last samples come back, then give the block its latency again
    // in case anything arrives that was never asked for.
    start <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.error_count == 0 && sb.pending_samples.size() == 0) begin
      $display("PASS wavetable_synth_voice_mixer_top");
    end else begin
      $display("FAIL wavetable_synth_voice_mixer_top");
    end
    $finish;
  end

  // Guard against a hung handshake; the slowest correct run is far shorter.
  initial begin
    #20ms;
    $display("FAIL wavetable_synth_voice_mixer_top");
    $finish;
  end

endmodule
